/* design/sft2d_pkg.sv */
// Shared types and constants for the 2D spring force and torque pipeline.
// Used by the square-root cell, the divider cell and the top level.
package sft2d_pkg;

  // Field widths.
  localparam int CW  = 32;  // coordinate and result width
  localparam int LW  = 33;  // spring length, offsets and magnitudes of differences
  localparam int SQW = 67;  // square-root remainder
  localparam int QW  = 32;  // quotient bits produced by the divider chain

  // Configuration register indexes and reset values.
  localparam logic CFG_STIFFNESS = 1'b0;
  localparam logic CFG_REST_LEN  = 1'b1;
  localparam logic signed [31:0] STIFF_RESET = 32'sd65536;
  localparam logic [30:0]        REST_RESET  = 31'd65536;

  // Per-item values that ride alongside the square-root chain.
  typedef struct packed {
    logic signed [LW-1:0] r1x;
    logic signed [LW-1:0] r1y;
    logic signed [LW-1:0] r2x;
    logic signed [LW-1:0] r2y;
    logic [LW-1:0]        dxm;
    logic [LW-1:0]        dym;
    logic                 dxn;
    logic                 dyn;
  } side_t;

  // Square-root cell payload: partial remainder, partial root and side data.
  typedef struct packed {
    logic [SQW-1:0] rem;
    logic [LW-1:0]  root;
    side_t          side;
  } sqrt_t;

  // Values needed after the length is known.
  typedef struct packed {
    logic [LW-1:0] len;
    logic          zero;
    logic          negx;
    logic          negy;
    side_t         side;
  } mid_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic          over;
    logic [LW-1:0] rem;
    logic [QW-1:0] lowb;
    logic [QW-1:0] quo;
  } div_lane_t;

  // Divider cell payload: both force components share the divisor.
  typedef struct packed {
    div_lane_t lx;
    div_lane_t ly;
    mid_t      mid;
  } div_t;

  // Result held in the output register and skid stage.
  typedef struct packed {
    logic [CW-1:0] twist_two;
    logic [CW-1:0] twist_one;
    logic [CW-1:0] push_y;
    logic [CW-1:0] push_x;
    logic          zero;
  } res_t;

endpackage

/* design/sft2d_sqrt_cell.sv */
// One cell of the square-root chain: decides one root bit per item.
// Depends on sft2d_pkg for the payload type.
module sft2d_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  sft2d_pkg::sqrt_t  in_data,
  output logic              out_valid,
  output sft2d_pkg::sqrt_t  out_data
);
  import sft2d_pkg::*;

  localparam logic [SQW-1:0] SQ_BIT   = SQW'(1) << (2 * BIT);
  localparam logic [LW-1:0]  ROOT_BIT = LW'(1) << BIT;

  logic [SQW-1:0] trial;
  logic           fits;
  sqrt_t          data_nxt;
  sqrt_t          data_r;
  logic           valid_r;

  // Trial square growth is 2*root*2^BIT + 2^(2*BIT); keep the bit if it fits.
  always_comb begin
    trial    = (SQW'(in_data.root) << (BIT + 1)) + SQ_BIT;
    fits     = in_data.rem >= trial;
    data_nxt = in_data;
    if (fits) begin
      data_nxt.rem  = in_data.rem - trial;
      data_nxt.root = in_data.root | ROOT_BIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* design/sft2d_div_cell.sv */
// One cell of the restoring divider chain: one quotient bit for each of two lanes.
// Depends on sft2d_pkg for the payload type.
module sft2d_div_cell #(
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  sft2d_pkg::div_t in_data,
  output logic            out_valid,
  output sft2d_pkg::div_t out_data
);
  import sft2d_pkg::*;

  div_t data_nxt;
  div_t data_r;
  logic valid_r;

  // Shift in the next dividend bit and subtract the length when it fits.
  function automatic div_lane_t div_step(div_lane_t l, logic [LW-1:0] len);
    logic [LW:0] part;
    div_lane_t   o;
    o    = l;
    part = {l.rem, l.lowb[BIT]};
    if (part >= {1'b0, len}) begin
      o.rem      = LW'(part - {1'b0, len});
      o.quo[BIT] = 1'b1;
    end else begin
      o.rem = part[LW-1:0];
    end
    return o;
  endfunction

  always_comb begin
    data_nxt    = in_data;
    data_nxt.lx = div_step(in_data.lx, in_data.mid.len);
    data_nxt.ly = div_step(in_data.ly, in_data.mid.len);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* design/spring_force_torque_2d.sv */
// Hooke spring force and body torques in 2D, fully pipelined: one spring request is
// accepted every cycle while the skid stage is empty. The pipeline is made up of the
// square-root chain (33 cells, one root bit each), the divider chain (32 cells, one
// quotient bit each), eleven arithmetic stages and the output register. A two-entry
// output (register plus skid stage) keeps the pipeline advancing after the result
// side stops until a result lands in the skid stage; the whole pipeline then holds.
// Depends on sft2d_pkg, sft2d_sqrt_cell and sft2d_div_cell.
module spring_force_torque_2d #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // anchor_one_x, anchor_one_y, anchor_two_x, anchor_two_y,
  // centre_one_x, centre_one_y, centre_two_x, centre_two_y (32 bits each, lowest first)
  input  logic [255:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // push_x, push_y, twist_one, twist_two (32 bits each, lowest first)
  output logic [127:0] out_tdata,
  // zero_length
  output logic         out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import sft2d_pkg::*;

  // Configuration registers.
  logic signed [31:0] stiff_r;
  logic [30:0]        rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= STIFF_RESET;
      rest_r  <= REST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STIFFNESS: stiff_r <= cfg_wdata;
        CFG_REST_LEN:  rest_r  <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances while the skid stage is empty.
  logic skid_v_r;
  logic en;
  assign en        = !skid_v_r;
  assign in_tready = en;

  // Saturate a magnitude with a sign to a signed 32-bit value.
  function automatic logic [CW-1:0] sat32(logic [64:0] mag, logic neg);
    logic [CW-1:0] r;
    if (neg) begin
      r = (mag >= 65'h0_8000_0000) ? 32'h8000_0000 : 32'(~mag + 65'd1);
    end else begin
      r = (mag > 65'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[CW-1:0];
    end
    return r;
  endfunction

  // Stage A: anchor differences, lever arms and their magnitudes.
  logic signed [LW-1:0] a1x, a1y, a2x, a2y, c1x, c1y, c2x, c2y, dx, dy;
  side_t                a_side_nxt, a_side_r;
  logic                 a_v_r;

  always_comb begin
    a1x = LW'($signed(in_tdata[31:0]));
    a1y = LW'($signed(in_tdata[63:32]));
    a2x = LW'($signed(in_tdata[95:64]));
    a2y = LW'($signed(in_tdata[127:96]));
    c1x = LW'($signed(in_tdata[159:128]));
    c1y = LW'($signed(in_tdata[191:160]));
    c2x = LW'($signed(in_tdata[223:192]));
    c2y = LW'($signed(in_tdata[255:224]));
    dx  = a2x - a1x;
    dy  = a2y - a1y;
    a_side_nxt.r1x = a1x - c1x;
    a_side_nxt.r1y = a1y - c1y;
    a_side_nxt.r2x = a2x - c2x;
    a_side_nxt.r2y = a2y - c2y;
    a_side_nxt.dxn = dx[LW-1];
    a_side_nxt.dyn = dy[LW-1];
    a_side_nxt.dxm = dx[LW-1] ? LW'(-dx) : LW'(dx);
    a_side_nxt.dym = dy[LW-1] ? LW'(-dy) : LW'(dy);
  end

  // Stage B: squares. Stage C: sum of squares into the root chain.
  logic [63:0] b_sx_r, b_sy_r;
  side_t       b_side_r;
  logic        b_v_r;
  sqrt_t       c_data_r;
  logic        c_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r      <= a_side_nxt;
      b_sx_r        <= 64'(a_side_r.dxm * a_side_r.dxm);
      b_sy_r        <= 64'(a_side_r.dym * a_side_r.dym);
      b_side_r      <= a_side_r;
      c_data_r.rem  <= SQW'(b_sx_r) + SQW'(b_sy_r);
      c_data_r.root <= '0;
      c_data_r.side <= b_side_r;
    end
  end

  // Square-root chain, most significant root bit first.
  sqrt_t sq_d [0:LW];
  logic  sq_v [0:LW];
  assign sq_d[0] = c_data_r;
  assign sq_v[0] = c_v_r;

  for (genvar gi = 0; gi < LW; gi++) begin : g_sqrt
    sft2d_sqrt_cell #(.BIT(LW - 1 - gi)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (sq_v[gi]),
      .in_data  (sq_d[gi]),
      .out_valid(sq_v[gi + 1]),
      .out_data (sq_d[gi + 1])
    );
  end

  // Stage D: stretch, its magnitude and the sign of each force component.
  logic signed [LW:0] stretch;
  logic [LW-1:0]      d_smag_r;
  logic [31:0]        d_kmag_r;
  mid_t               d_mid_r;
  logic               d_v_r;
  logic               ks_neg;

  always_comb begin
    stretch = $signed({1'b0, sq_d[LW].root}) - $signed({3'b000, rest_r});
    ks_neg  = stiff_r[31] ^ stretch[LW];
  end

  // Stage E: stiffness times stretch. Stage F: partial products with the deltas.
  logic [63:0] e_ks_r;
  mid_t        e_mid_r;
  logic        e_v_r;
  logic [64:0] f_pxl_r, f_pxh_r, f_pyl_r, f_pyh_r;
  mid_t        f_mid_r;
  logic        f_v_r;

  // Stage G: full dividend, scaled down, and the quotient overflow check.
  logic [96:0] nx, ny, nxs, nys;
  div_t        g_nxt, g_data_r;
  logic        g_v_r;

  always_comb begin
    nx  = {f_pxh_r, 32'b0} + 97'(f_pxl_r);
    ny  = {f_pyh_r, 32'b0} + 97'(f_pyl_r);
    nxs = nx >> FRAC_BITS;
    nys = ny >> FRAC_BITS;
    g_nxt.mid     = f_mid_r;
    g_nxt.lx.over = nxs[96:32] >= 65'(f_mid_r.len);
    g_nxt.lx.rem  = nxs[64:32];
    g_nxt.lx.lowb = nxs[31:0];
    g_nxt.lx.quo  = '0;
    g_nxt.ly.over = nys[96:32] >= 65'(f_mid_r.len);
    g_nxt.ly.rem  = nys[64:32];
    g_nxt.ly.lowb = nys[31:0];
    g_nxt.ly.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_smag_r     <= stretch[LW] ? LW'(-stretch) : LW'(stretch);
      d_kmag_r     <= stiff_r[31] ? 32'(-stiff_r) : 32'(stiff_r);
      d_mid_r.len  <= sq_d[LW].root;
      d_mid_r.zero <= sq_d[LW].root == '0;
      d_mid_r.negx <= ks_neg ^ sq_d[LW].side.dxn;
      d_mid_r.negy <= ks_neg ^ sq_d[LW].side.dyn;
      d_mid_r.side <= sq_d[LW].side;
      e_ks_r       <= 64'(d_kmag_r * d_smag_r);
      e_mid_r      <= d_mid_r;
      f_pxl_r      <= 65'(e_ks_r[31:0] * e_mid_r.side.dxm);
      f_pxh_r      <= 65'(e_ks_r[63:32] * e_mid_r.side.dxm);
      f_pyl_r      <= 65'(e_ks_r[31:0] * e_mid_r.side.dym);
      f_pyh_r      <= 65'(e_ks_r[63:32] * e_mid_r.side.dym);
      f_mid_r      <= e_mid_r;
      g_data_r     <= g_nxt;
    end
  end

  // Divider chain, most significant quotient bit first.
  div_t dv_d [0:QW];
  logic dv_v [0:QW];
  assign dv_d[0] = g_data_r;
  assign dv_v[0] = g_v_r;

  for (genvar gi = 0; gi < QW; gi++) begin : g_div
    sft2d_div_cell #(.BIT(QW - 1 - gi)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (dv_v[gi]),
      .in_data  (dv_d[gi]),
      .out_valid(dv_v[gi + 1]),
      .out_data (dv_d[gi + 1])
    );
  end

  // Stage H: saturated force, zero when the anchors coincide.
  div_t                 dv_o;
  logic [64:0]          magx, magy;
  logic signed [CW-1:0] h_fx_r, h_fy_r;
  side_t                h_side_r;
  logic                 h_zero_r;
  logic                 h_v_r;

  always_comb begin
    dv_o = dv_d[QW];
    magx = dv_o.lx.over ? 65'h1_0000_0000 : 65'(dv_o.lx.quo);
    magy = dv_o.ly.over ? 65'h1_0000_0000 : 65'(dv_o.ly.quo);
  end

  // Stage I: cross-product terms. Stage J: differences. Stage K: scale and saturate.
  logic signed [64:0] i_p1a_r, i_p1b_r, i_p2a_r, i_p2b_r;
  logic               i_zero_r, i_v_r;
  logic signed [65:0] j_d1_r, j_d2_r;
  logic               j_zero_r, j_v_r;
  logic [65:0]        m1, m2, m1s, m2s;
  logic [CW-1:0]      j_fx_r, j_fy_r, i_fx_r, i_fy_r;
  res_t               k_nxt, k_data_r;
  logic               k_v_r;

  always_comb begin
    m1  = j_d1_r[65] ? 66'(-j_d1_r) : 66'(j_d1_r);
    m2  = j_d2_r[65] ? 66'(-j_d2_r) : 66'(j_d2_r);
    m1s = m1 >> FRAC_BITS;
    m2s = m2 >> FRAC_BITS;
    k_nxt.push_x    = j_fx_r;
    k_nxt.push_y    = j_fy_r;
    k_nxt.twist_one = sat32(m1s[64:0], j_d1_r[65]);
    k_nxt.twist_two = sat32(m2s[64:0], !j_d2_r[65]);
    k_nxt.zero      = j_zero_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_fx_r   <= dv_o.mid.zero ? '0 : sat32(magx, dv_o.mid.negx);
      h_fy_r   <= dv_o.mid.zero ? '0 : sat32(magy, dv_o.mid.negy);
      h_side_r <= dv_o.mid.side;
      h_zero_r <= dv_o.mid.zero;
      i_p1a_r  <= 65'(h_side_r.r1x * h_fy_r);
      i_p1b_r  <= 65'(h_side_r.r1y * h_fx_r);
      i_p2a_r  <= 65'(h_side_r.r2x * h_fy_r);
      i_p2b_r  <= 65'(h_side_r.r2y * h_fx_r);
      i_fx_r   <= h_fx_r;
      i_fy_r   <= h_fy_r;
      i_zero_r <= h_zero_r;
      j_d1_r   <= 66'(i_p1a_r) - 66'(i_p1b_r);
      j_d2_r   <= 66'(i_p2a_r) - 66'(i_p2b_r);
      j_fx_r   <= i_fx_r;
      j_fy_r   <= i_fy_r;
      j_zero_r <= i_zero_r;
      k_data_r <= k_nxt;
    end
  end

  // Valid bits of the arithmetic stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
      i_v_r <= 1'b0;
      j_v_r <= 1'b0;
      k_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_tvalid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= sq_v[LW];
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
      h_v_r <= dv_v[QW];
      i_v_r <= h_v_r;
      j_v_r <= i_v_r;
      k_v_r <= j_v_r;
    end
  end

  // Output register with a skid stage behind it.
  res_t out_r, skid_r;
  logic out_v_r;
  logic push;
  assign push = en && k_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_tready) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_v_r && !out_tready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_r <= skid_r;
      end
    end else if (push) begin
      if (out_v_r && !out_tready) begin
        skid_r <= k_data_r;
      end else begin
        out_r <= k_data_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.twist_two, out_r.twist_one, out_r.push_y, out_r.push_x};
  assign out_tuser  = out_r.zero;

endmodule

/* design/sft2d_checker.sv */
// Port-level checks for spring_force_torque_2d, attached by the bind below.
// Sees only the top level's ports.
module sft2d_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [127:0] out_tdata,
  input logic         out_tuser,
  input logic         out_tvalid,
  input logic         out_tready
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Coincident anchors give zero force and torques.
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("zero-length result carries nonzero data");

  // Requests are refused only after the result side has stalled.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("request refused without a stalled result");

endmodule

bind spring_force_torque_2d sft2d_checker u_sft2d_checker (.*);

/* sim/spring_force_torque_2d_tb.sv */
// Self-checking bench for the 2D Hooke spring force and torque pipeline.
// Drives spring requests, predicts force, torques and the zero-length flag, and compares.
// Depends on sft2d_pkg and spring_force_torque_2d.
module spring_force_torque_2d_tb;
  import sft2d_pkg::*;

  localparam int FB = 16;

  typedef struct packed {
    logic [31:0] twist_two;
    logic [31:0] twist_one;
    logic [31:0] push_y;
    logic [31:0] push_x;
    logic        zero;
  } spring_res_t;

  logic         clk, rst_n;
  logic [255:0] in_tdata;
  logic         in_tvalid, in_tready;
  logic [127:0] out_tdata;
  logic         out_tuser, out_tvalid, out_tready;
  logic         cfg_we, cfg_index;
  logic [31:0]  cfg_wdata;

  spring_force_torque_2d uut (.*);

  logic signed [31:0] stiff_q;
  logic [30:0]        rest_q;

  logic [255:0]  pending_springs[$];
  spring_res_t   expected_forces[$];
  int            mismatches = 0;
  bit            tx_idle_en = 1, rx_idle_en = 1;
  bit            tx_hold = 0;
  int            rx_hold_cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
    if (v > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -128'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Exact arithmetic in wide signed vectors; division truncates toward zero.
  function automatic spring_res_t predict_spring(logic [255:0] d);
    spring_res_t r;
    logic signed [127:0] a1x, a1y, a2x, a2y, c1x, c1y, c2x, c2y, dx, dy;
    logic signed [127:0] sq, len, ks, den, fx, fy, t;
    logic [127:0] root, trial;
    a1x = $signed(d[31:0]);    a1y = $signed(d[63:32]);
    a2x = $signed(d[95:64]);   a2y = $signed(d[127:96]);
    c1x = $signed(d[159:128]); c1y = $signed(d[191:160]);
    c2x = $signed(d[223:192]); c2y = $signed(d[255:224]);
    dx = a2x - a1x; dy = a2y - a1y;
    sq = dx * dx + dy * dy;
    root = 0;
    for (int b = 33; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    len = root;
    r = '0;
    if (len == 0) begin
      r.zero = 1'b1;
      return r;
    end
    ks = stiff_q * (len - $signed({97'd0, rest_q}));
    den = len <<< FB;
    fx = clamp32((ks * dx) / den);
    fy = clamp32((ks * dy) / den);
    t = (a1x - c1x) * fy - (a1y - c1y) * fx;
    r.twist_one = clamp32(t / (128'sd1 <<< FB));
    t = -((a2x - c2x) * fy - (a2y - c2y) * fx);
    r.twist_two = clamp32(t / (128'sd1 <<< FB));
    r.push_x = fx[31:0];
    r.push_y = fy[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("force check: %s got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Driver: offers pending requests with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_forces.push_back(predict_spring(in_tdata));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_springs.size() > 0 && !tx_hold &&
            !(tx_idle_en && $urandom_range(99) < 22)) begin
          in_tdata  <= pending_springs.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and comparison with the oldest expectation.
  always @(posedge clk) begin
    spring_res_t w;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_forces.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], 32'd0);
        end else begin
          w = expected_forces.pop_front();
          if (out_tdata[31:0] !== w.push_x) report_mismatch("push_x", out_tdata[31:0], w.push_x);
          if (out_tdata[63:32] !== w.push_y) report_mismatch("push_y", out_tdata[63:32], w.push_y);
          if (out_tdata[95:64] !== w.twist_one)
            report_mismatch("twist_one", out_tdata[95:64], w.twist_one);
          if (out_tdata[127:96] !== w.twist_two)
            report_mismatch("twist_two", out_tdata[127:96], w.twist_two);
          if (out_tuser !== w.zero)
            report_mismatch("zero_length", {31'd0, out_tuser}, {31'd0, w.zero});
        end
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles <= rx_hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(rx_idle_en && $urandom_range(99) < 22);
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'h80000000 | $urandom_range(3);
      2: return 32'h7FFFFFFF - $urandom_range(3);
      3: return $urandom_range(65535) - 32768;
      default: return ($urandom_range(400000) - 200000) << $urandom_range(8);
    endcase
  endfunction

  function automatic logic [255:0] rand_spring();
    logic [255:0] d;
    for (int i = 0; i < 8; i++) d[i*32 +: 32] = rand_coord();
    // Sometimes make the anchors coincide or sit very close.
    if ($urandom_range(15) == 0) d[127:64] = d[63:0];
    else if ($urandom_range(15) == 0) d[127:64] = d[63:0] + $urandom_range(3);
    return d;
  endfunction

  task automatic drain_all();
    wait (pending_springs.size() == 0 && !in_tvalid && expected_forces.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STIFFNESS) stiff_q = v;
    else rest_q = v[30:0];
  endtask

  initial begin
    logic [31:0] stiff_set[6];
    logic [31:0] rest_set[6];
    logic [255:0] d;
    stiff_set = '{32'h00010000, 32'h80000000, 32'h7FFFFFFF, 32'h00000000,
                  32'hFFFF0000, 32'h00000001};
    rest_set  = '{32'h00010000, 32'h00000000, 32'h7FFFFFFF, 32'h00000001,
                  32'h00500000, 32'h00000100};
    rst_n = 0; in_tdata = '0; in_tvalid = 0; out_tready = 0;
    cfg_we = 0; cfg_index = CFG_STIFFNESS; cfg_wdata = '0;
    stiff_q = STIFF_RESET; rest_q = REST_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, coincident anchors, axis-aligned and diagonal springs.
    pending_springs.push_back('0);
    pending_springs.push_back({8{32'h7FFFFFFF}});
    pending_springs.push_back({{4{32'h7FFFFFFF}}, 32'h80000000, 32'h80000000,
                               32'h7FFFFFFF, 32'h7FFFFFFF});
    pending_springs.push_back({{4{32'h80000000}}, 32'h7FFFFFFF, 32'h7FFFFFFF,
                               32'h80000000, 32'h80000000});
    pending_springs.push_back({128'h0, 32'd0, 32'h00020000, 32'd0, 32'd0});
    pending_springs.push_back({128'h0, 32'h00030000, 32'd0, 32'd0, 32'd0});
    pending_springs.push_back({32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                               32'h00000001, 32'h00000001, 32'd0, 32'd0});
    pending_springs.push_back({{4{32'h12345678}}, 32'h00001000, 32'h00001000,
                               32'h00001000, 32'h00001000});
    pending_springs.push_back({128'h0, 32'd1, 32'd0, 32'd0, 32'd0});
    drain_all();

    // Random phases over several register settings, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_STIFFNESS, ph == 0 ? stiff_set[0] : stiff_set[ph]);
      write_reg(CFG_REST_LEN, rest_set[ph]);
      tx_idle_en = (ph != 2);
      rx_idle_en = (ph != 2);
      for (int i = 0; i < 290; i++) pending_springs.push_back(rand_spring());
      if (ph == 3) begin
        // Long receiver stall while the sender keeps offering.
        rx_hold_cycles = 300;
      end
      if (ph == 4) begin
        // Sender pauses mid-phase until every result is back.
        wait (pending_springs.size() < 150);
        tx_hold = 1;
        wait (!in_tvalid && expected_forces.size() == 0);
        tx_hold = 0;
      end
      drain_all();
    end

    if (mismatches == 0) begin
      $display("spring_force_torque_2d: match");
    end else begin
      $display("spring_force_torque_2d: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("spring_force_torque_2d: mismatch");
    $finish;
  end
endmodule
